// ----- rtl/core/eavr_pkg.sv -----
// Package for the Euler-angle vector rotation block.
// Holds CORDIC constants, the convention codes and the rounding helpers.
// No dependencies.
`default_nettype none
package eavr_pkg;
  localparam int CordicSteps = 24;
  localparam int CoefBits = 24;
  localparam int CoefW = CoefBits + 2;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032875;

  typedef enum logic [1:0] {
    CONV_ZYZ_FIXED = 2'd0,
    CONV_ZYZ_ALT   = 2'd1,
    CONV_ZY_TWO    = 2'd2,
    CONV_RSVD      = 2'd3
  } conv_t;

  typedef logic signed [CoefW-1:0] coef_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      unique case (i)
        5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
        default: r = '0;
      endcase
      atan_entry = r;
    end
  endfunction

  // Clamp to [-1, 1] in coefficient units.
  function automatic coef_t clamp_unit(input logic signed [CoefW+1:0] v);
    logic signed [CoefW+1:0] one;
    begin
      one = (CoefW+2)'(1) <<< CoefBits;
      if (v > one) clamp_unit = CoefW'(one);
      else if (v < -one) clamp_unit = CoefW'(-one);
      else clamp_unit = CoefW'(v);
    end
  endfunction

  // Round half up a coefficient product back to coefficient scale.
  function automatic logic signed [CoefW+1:0] mulr(input coef_t a, input coef_t b);
    logic signed [2*CoefW-1:0] p;
    begin
      p = a * b + (2*CoefW)'(64'sd1 <<< (CoefBits-1));
      mulr = (CoefW+2)'(p >>> CoefBits);
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/eavr_cordic.sv -----
// Pipelined CORDIC: one stage per step, cosine and sine of one angle.
// Depends on eavr_pkg.
`default_nettype none
module eavr_cordic #(
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [ANGLE_WIDTH-1:0] angle,
  output eavr_pkg::coef_t cos_out,
  output eavr_pkg::coef_t sin_out
);
  import eavr_pkg::*;
  localparam int N = CordicSteps;
  localparam int Sh = 30 - CoefBits;

  logic signed [CordicW-1:0] xs [N+1];
  logic signed [CordicW-1:0] ys [N+1];
  logic signed [33:0] zs [N+1];
  logic flips [N+1];
  logic [31:0] a32, af;

  // Fold the angle into the right half plane
  always_comb begin
    a32 = {angle, (32-ANGLE_WIDTH)'(0)};
    af = a32 ^ {a32[31] ^ a32[30], 31'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CordicGain;
      ys[0] <= '0;
      zs[0] <= 34'(signed'(af));
      flips[0] <= a32[31] ^ a32[30];
    end
  end

  // Advance one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CordicW-1:0] dx, dy;
    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        flips[i+1] <= flips[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - atan_entry(5'(i));
        end else begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + atan_entry(5'(i));
        end
      end
    end
  end

  // Round, clamp and undo the fold
  logic signed [CordicW-1:0] xr, yr;
  coef_t xc, yc;
  always_comb begin
    xr = (xs[N] + CordicW'(1 <<< (Sh-1))) >>> Sh;
    yr = (ys[N] + CordicW'(1 <<< (Sh-1))) >>> Sh;
    xc = clamp_unit((CoefW+2)'(xr));
    yc = clamp_unit((CoefW+2)'(yr));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= flips[N] ? -xc : xc;
      sin_out <= flips[N] ? -yc : yc;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/eavr_front.sv -----
// Front part: trig pipelines and matrix build, into a queue.
// Depends on eavr_pkg and eavr_cordic.
`default_nettype none
module eavr_front #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [1:0] conv,
  input  wire logic [3*COMPONENT_WIDTH-1:0] vec_in,
  input  wire logic [3*ANGLE_WIDTH-1:0] ang_in,
  output logic out_valid,
  output logic [3*COMPONENT_WIDTH-1:0] vec_out,
  output eavr_pkg::coef_t mat_out [9]
);
  import eavr_pkg::*;
  localparam int Lat = CordicSteps + 2;

  coef_t ca, sa, cb, sb, cg, sg;
  eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_a (.clk, .en,
    .angle(ang_in[ANGLE_WIDTH-1:0]), .cos_out(ca), .sin_out(sa));
  eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_b (.clk, .en,
    .angle(ang_in[2*ANGLE_WIDTH-1:ANGLE_WIDTH]), .cos_out(cb), .sin_out(sb));
  eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_g (.clk, .en,
    .angle(ang_in[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]), .cos_out(cg), .sin_out(sg));

  // Carry valid, vector and mode beside the CORDIC
  logic vld [Lat+2];
  logic [3*COMPONENT_WIDTH-1:0] vd [Lat+2];
  logic [1:0] md [Lat+2];
  always_ff @(posedge clk) begin
    if (en) begin
      vd[0] <= vec_in;
      md[0] <= conv;
      for (int i = 1; i < Lat+2; i++) begin
        vd[i] <= vd[i-1];
        md[i] <= md[i-1];
      end
    end
    if (rst) begin
      for (int i = 0; i < Lat+2; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < Lat+2; i++) vld[i] <= vld[i-1];
    end
  end

  // First product rank
  logic signed [CoefW+1:0] p_cbsa, p_cbca, p_sbsa, p_sbca, p_sbsg, p_sbcg;
  logic signed [CoefW+1:0] p_cacg, p_sacg, p_sasg, p_casg, p_cgcb, p_sgcb;
  logic signed [CoefW+1:0] p_sgsa, p_cgsa, p_sgca, p_cgca, p_cgsb, p_sgsb;
  coef_t r_ca, r_sa, r_cb, r_sb, r_cg, r_sg;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cbsa <= mulr(cb, sa); p_cbca <= mulr(cb, ca);
      p_sbsa <= mulr(sb, sa); p_sbca <= mulr(sb, ca);
      p_sbsg <= mulr(sb, sg); p_sbcg <= mulr(sb, cg);
      p_cacg <= mulr(ca, cg); p_sacg <= mulr(sa, cg);
      p_sasg <= mulr(sa, sg); p_casg <= mulr(ca, sg);
      p_cgcb <= mulr(cg, cb); p_sgcb <= mulr(sg, cb);
      p_sgsa <= mulr(sg, sa); p_cgsa <= mulr(cg, sa);
      p_sgca <= mulr(sg, ca); p_cgca <= mulr(cg, ca);
      p_cgsb <= mulr(cg, sb); p_sgsb <= mulr(sg, sb);
      r_ca <= ca; r_sa <= sa; r_cb <= cb; r_sb <= sb; r_cg <= cg; r_sg <= sg;
    end
  end

  // Second rank and matrix entries
  function automatic coef_t c2(input logic signed [CoefW+1:0] v);
    c2 = CoefW'(v);
  endfunction
  logic signed [CoefW+1:0] m [9];
  always_comb begin
    unique case (conv_t'(md[Lat]))
      CONV_ZYZ_ALT: begin
        m[0] = -mulr(c2(p_cbsa), r_sg) + p_cacg;
        m[1] = -mulr(c2(p_cbsa), r_cg) - p_casg;
        m[2] = p_sbsa;
        m[3] = mulr(c2(p_cbca), r_sg) + p_sacg;
        m[4] = mulr(c2(p_cbca), r_cg) - p_sasg;
        m[5] = -p_sbca;
        m[6] = p_sbsg;
        m[7] = p_sbcg;
        m[8] = (CoefW+2)'(r_cb);
      end
      CONV_ZY_TWO: begin
        m[0] = p_cbca;
        m[1] = -p_cbsa;
        m[2] = (CoefW+2)'(r_sb);
        m[3] = (CoefW+2)'(r_sa);
        m[4] = (CoefW+2)'(r_ca);
        m[5] = '0;
        m[6] = -p_sbca;
        m[7] = p_sbsa;
        m[8] = (CoefW+2)'(r_cb);
      end
      default: begin
        m[0] = mulr(c2(p_cgcb), r_ca) - p_sgsa;
        m[1] = -mulr(c2(p_cgcb), r_sa) - p_sgca;
        m[2] = p_cgsb;
        m[3] = mulr(c2(p_sgcb), r_ca) + p_cgsa;
        m[4] = -mulr(c2(p_sgcb), r_sa) + p_cgca;
        m[5] = p_sgsb;
        m[6] = -p_sbca;
        m[7] = p_sbsa;
        m[8] = (CoefW+2)'(r_cb);
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) mat_out[k] <= clamp_unit(m[k]);
    end
  end
  assign out_valid = vld[Lat+1];
  assign vec_out = vd[Lat+1];
endmodule
`default_nettype wire

// ----- rtl/core/eavr_back.sv -----
// Back part: queue of matrix items, dot products, rounding, saturation.
// Depends on eavr_pkg.
`default_nettype none
module eavr_back #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [3*COMPONENT_WIDTH-1:0] vec_in,
  input  wire eavr_pkg::coef_t mat_in [9],
  output logic [5:0] used,
  output logic m_valid,
  input  wire logic m_ready,
  output logic [3*COMPONENT_WIDTH:0] m_data
);
  import eavr_pkg::*;
  localparam int Depth = 32;
  localparam int Pw = COMPONENT_WIDTH + CoefW;
  localparam int Aw = Pw + 2;
  localparam int EntryW = 3*COMPONENT_WIDTH + 9*CoefW;

  // Queue memory between matrix build and the dot-product stages
  logic [EntryW-1:0] mem [Depth];
  logic [4:0] wp, rp;
  logic [5:0] cnt;
  logic [EntryW-1:0] wdata, rdata;
  logic pop, rvalid, adv;
  always_comb begin
    wdata[3*COMPONENT_WIDTH-1:0] = vec_in;
    for (int k = 0; k < 9; k++)
      wdata[3*COMPONENT_WIDTH + k*CoefW +: CoefW] = mat_in[k];
  end
  always_ff @(posedge clk) begin
    if (in_valid) mem[wp] <= wdata;
    if (pop) rdata <= mem[rp];
  end

  // Output stages: s1 products, s2 sum, s3 result register
  logic v1, v2, v3;
  assign adv = !v3 || m_ready;
  assign pop = (cnt != 6'd0) && (!rvalid || adv);
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; rvalid <= 1'b0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (in_valid) wp <= wp + 5'd1;
      if (pop) rp <= rp + 5'd1;
      cnt <= cnt + 6'(in_valid) - 6'(pop);
      if (pop) rvalid <= 1'b1; else if (adv) rvalid <= 1'b0;
      if (adv) begin
        v1 <= rvalid; v2 <= v1; v3 <= v2;
      end
    end
  end
  assign used = cnt + 6'(rvalid) + 6'(v1) + 6'(v2) + 6'(v3);

  logic signed [Pw-1:0] prod [9];
  logic signed [Aw-1:0] sum [3];
  logic [3*COMPONENT_WIDTH:0] res;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          prod[r*3+k] <= $signed(rdata[k*COMPONENT_WIDTH +: COMPONENT_WIDTH])
            * $signed(rdata[3*COMPONENT_WIDTH + (r*3+k)*CoefW +: CoefW]);
      for (int r = 0; r < 3; r++)
        sum[r] <= Aw'(prod[r*3]) + Aw'(prod[r*3+1]) + Aw'(prod[r*3+2]);
      m_data <= res;
    end
  end

  // Round half up and saturate
  logic signed [Aw-1:0] rs;
  logic signed [Aw-1:0] maxv, minv;
  always_comb begin
    maxv = Aw'((64'sd1 <<< (COMPONENT_WIDTH-1)) - 1);
    minv = -maxv - Aw'(1);
    res = '0;
    for (int r = 0; r < 3; r++) begin
      rs = (sum[r] + Aw'(64'sd1 <<< (CoefBits-1))) >>> CoefBits;
      if (rs > maxv) begin
        res[r*COMPONENT_WIDTH +: COMPONENT_WIDTH] = COMPONENT_WIDTH'(maxv);
        res[3*COMPONENT_WIDTH] = 1'b1;
      end else if (rs < minv) begin
        res[r*COMPONENT_WIDTH +: COMPONENT_WIDTH] = COMPONENT_WIDTH'(minv);
        res[3*COMPONENT_WIDTH] = 1'b1;
      end else begin
        res[r*COMPONENT_WIDTH +: COMPONENT_WIDTH] = COMPONENT_WIDTH'(rs);
      end
    end
  end
  assign m_valid = v3;
endmodule
`default_nettype wire

// ----- rtl/core/euler_angle_vector_rotation.sv -----
// Euler-angle vector rotation: CORDIC trig, matrix build, matrix-vector product.
// Throughput one item per cycle while s_axis_tready is high, set by the fully
// pipelined CORDIC and multipliers. A 32-entry queue absorbs the front pipeline;
// input stalls once in-flight items fill it. rst is synchronous, active high;
// it clears valids, queue pointers and the mode.
`default_nettype none
module euler_angle_vector_rotation #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // vec_x, vec_y, vec_z, angle_first, angle_second, angle_third (low to high)
  input  wire logic [((3*COMPONENT_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // rot_x, rot_y, rot_z, overflow (low to high)
  output logic [((3*COMPONENT_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
  import eavr_pkg::*;
  localparam int Vw = 3*COMPONENT_WIDTH;
  localparam int FrontLat = CordicSteps + 3;
  localparam int OutW = ((Vw+1+7)/8)*8;

  // Hold the convention register
  logic [1:0] conv;
  always_ff @(posedge clk) begin
    if (rst) conv <= 2'd0;
    else if (cfg_we) conv <= cfg_wdata;
  end

  logic [5:0] used;
  logic fv;
  logic [Vw-1:0] fvec;
  coef_t fmat [9];
  logic [Vw:0] res;

  // Admit while queue plus front pipeline cannot overflow
  assign s_axis_tready = (32'(used) + FrontLat <= 32) || (FRACTION_BITS < 0);

  eavr_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk, .rst, .en(1'b1),
    .in_valid(s_axis_tvalid && s_axis_tready),
    .conv,
    .vec_in(s_axis_tdata[Vw-1:0]),
    .ang_in(s_axis_tdata[Vw +: 3*ANGLE_WIDTH]),
    .out_valid(fv), .vec_out(fvec), .mat_out(fmat)
  );

  eavr_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
    .clk, .rst, .in_valid(fv), .vec_in(fvec), .mat_in(fmat), .used,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(res)
  );
  assign m_axis_tdata = OutW'(res);
endmodule
`default_nettype wire

// ----- bench/eavr_checker.sv -----
// Checker for the Euler-angle vector rotation block: watches both streams,
// predicts each rotated vector from the accepted item and compares field by field.
// Depends on eavr_pkg for the convention codes.
`timescale 1ns / 1ps
module eavr_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic s_axis_tvalid,
  input  wire logic s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,
  input  wire logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  input  wire logic [103:0] m_axis_tdata,
  output int fail_count,
  output int pending
);
  import eavr_pkg::*;

  localparam longint CoefOne = 64'sd1 <<< 24;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic ovf;
  } rot_t;

  const longint arctan_tbl[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  conv_t mode;
  rot_t rot_queue[$];

  // Arithmetic shift is a floor division in SystemVerilog.
  function automatic longint rnd_shift(longint v, int s);
    rnd_shift = (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > CoefOne) unit_clamp = CoefOne;
    else if (v < -CoefOne) unit_clamp = -CoefOne;
    else unit_clamp = v;
  endfunction

  function automatic longint cmul(longint a, longint b);
    cmul = rnd_shift(a * b, 24);
  endfunction

  // Sine and cosine by CORDIC, with half-turn folding.
  function automatic void sincos(input logic [15:0] ang, output longint c,
                                 output longint s);
    logic [31:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0};
    flip = a[31] ^ a[30];
    if (flip) a[31] = ~a[31];
    x = 652032875;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tbl[i];
      end else begin
        x += dx; y -= dy; z += arctan_tbl[i];
      end
    end
    x = unit_clamp(rnd_shift(x, 6));
    y = unit_clamp(rnd_shift(y, 6));
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic rot_t predict_rotation(logic [143:0] d, conv_t cv);
    longint v[3], m[9], acc;
    longint ca, sa, cb, sb, cg, sg;
    logic signed [31:0] outv[3];
    rot_t r;
    v[0] = longint'($signed(d[31:0]));
    v[1] = longint'($signed(d[63:32]));
    v[2] = longint'($signed(d[95:64]));
    sincos(d[111:96], ca, sa);
    sincos(d[127:112], cb, sb);
    sincos(d[143:128], cg, sg);
    r.ovf = 1'b0;
    case (cv)
      CONV_ZYZ_ALT: begin
        m[0] = -cmul(cmul(cb, sa), sg) + cmul(ca, cg);
        m[1] = -cmul(cmul(cb, sa), cg) - cmul(ca, sg);
        m[2] = cmul(sb, sa);
        m[3] = cmul(cmul(cb, ca), sg) + cmul(sa, cg);
        m[4] = cmul(cmul(cb, ca), cg) - cmul(sa, sg);
        m[5] = -cmul(sb, ca);
        m[6] = cmul(sb, sg);
        m[7] = cmul(sb, cg);
        m[8] = cb;
      end
      CONV_ZY_TWO: begin
        m[0] = cmul(cb, ca);
        m[1] = -cmul(cb, sa);
        m[2] = sb;
        m[3] = sa;
        m[4] = ca;
        m[5] = 0;
        m[6] = -cmul(sb, ca);
        m[7] = cmul(sb, sa);
        m[8] = cb;
      end
      default: begin
        m[0] = cmul(cmul(cg, cb), ca) - cmul(sg, sa);
        m[1] = -cmul(cmul(cg, cb), sa) - cmul(sg, ca);
        m[2] = cmul(cg, sb);
        m[3] = cmul(cmul(sg, cb), ca) + cmul(cg, sa);
        m[4] = -cmul(cmul(sg, cb), sa) + cmul(cg, ca);
        m[5] = cmul(sg, sb);
        m[6] = -cmul(sb, ca);
        m[7] = cmul(sb, sa);
        m[8] = cb;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += v[j] * unit_clamp(m[k * 3 + j]);
      acc = rnd_shift(acc, 24);
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647; r.ovf = 1'b1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648; r.ovf = 1'b1;
      end
      outv[k] = acc[31:0];
    end
    r.rx = outv[0];
    r.ry = outv[1];
    r.rz = outv[2];
    return r;
  endfunction

  assign pending = rot_queue.size();

  // Track the mode, queue predictions and compare results at each edge.
  always @(posedge clk) begin
    rot_t e;
    int errs;
    errs = 0;
    if (rst) begin
      mode <= CONV_ZYZ_FIXED;
      rot_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) mode <= conv_t'(cfg_wdata);
      if (s_axis_tvalid && s_axis_tready)
        rot_queue.push_back(predict_rotation(s_axis_tdata, mode));
      if (m_axis_tvalid && m_axis_tready) begin
        if (rot_queue.size() == 0) begin
          $error("result with no expectation waiting");
          errs++;
        end else begin
          e = rot_queue.pop_front();
          if (m_axis_tdata[31:0] !== e.rx) begin
            $error("rot_x expected %0d actual %0d", e.rx, $signed(m_axis_tdata[31:0]));
            errs++;
          end
          if (m_axis_tdata[63:32] !== e.ry) begin
            $error("rot_y expected %0d actual %0d", e.ry, $signed(m_axis_tdata[63:32]));
            errs++;
          end
          if (m_axis_tdata[95:64] !== e.rz) begin
            $error("rot_z expected %0d actual %0d", e.rz, $signed(m_axis_tdata[95:64]));
            errs++;
          end
          if (m_axis_tdata[96] !== e.ovf) begin
            $error("overflow expected %0d actual %0d", e.ovf, m_axis_tdata[96]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- bench/tb_euler_angle_vector_rotation.sv -----
// Testbench top for the Euler-angle vector rotation block: drives vectors and
// angles through each convention with random stalls and gives the verdict.
// Depends on eavr_pkg, the block and eavr_checker.
`timescale 1ns / 1ps
module tb_euler_angle_vector_rotation;
  import eavr_pkg::*;

  localparam int WatchLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit quiet_tail = 0;
  bit hold_off = 0;
  bit hold_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_angle_vector_rotation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  eavr_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stall bursts, one long hold-off, none in the tail.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_done = 1;
        m_axis_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted item and no delivered result.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: rand_comp = 32'h7fffffff;
      1: rand_comp = 32'h80000000;
      2: rand_comp = $urandom_range(0, 65536 * 4);
      3: rand_comp = -$urandom_range(0, 65536 * 4);
      default: rand_comp = $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: rand_angle = 16'h0000;
      1: rand_angle = 16'h4000;
      2: rand_angle = 16'h8000;
      3: rand_angle = 16'hc000;
      4: rand_angle = 16'h7fff;
      default: rand_angle = 16'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until accepted; maybe idle first.
  task automatic send_item(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [15:0] a1,
                           input logic [15:0] a2, input logic [15:0] a3);
    int n;
    if (!quiet_tail && !hold_off && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {a3, a2, a1, z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drain the pipeline, then write the mode while idle.
  task automatic set_mode(input conv_t cv);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    conv_t modes[5] = '{CONV_ZYZ_FIXED, CONV_ZYZ_ALT, CONV_ZY_TWO, CONV_RSVD,
                        CONV_ZYZ_ALT};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, quarter turns, third angle ignored in two-angle mode.
    foreach (modes[m]) begin
      set_mode(modes[m]);
      send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0000, 16'h0000, 16'h0000);
      send_item(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000);
      send_item(32'h7fffffff, 32'h80000000, 32'h00010000, 16'h2000, 16'h7fff, 16'hffff);
      send_item(32'h00010000, 32'h00000000, 32'hffff0000, 16'h4000, 16'hc000, 16'h1234);
      send_item(32'hffffffff, 32'h00000001, 32'h7fffffff, 16'hbfff, 16'h3fff, 16'h4000);
    end

    // Random part across each convention, with a long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(modes[ph]);
      for (int i = 0; i < 325; i++) begin
        if (ph == 1 && i == 50) hold_off = 1;
        if (hold_done) hold_off = 0;
        if (ph == 3 && i > 260) quiet_tail = 1;
        send_item(rand_comp(), rand_comp(), rand_comp(),
                  rand_angle(), rand_angle(), rand_angle());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/eavr_pkg.sv
rtl/core/eavr_cordic.sv
rtl/core/eavr_front.sv
rtl/core/eavr_back.sv
rtl/core/euler_angle_vector_rotation.sv
bench/eavr_checker.sv
bench/tb_euler_angle_vector_rotation.sv
